>>> design/rlbt_pkg.sv
// Shared types, constants and microcode ROM of the raster line, box and triangle plotter.
`timescale 1ns / 1ps

package rlbt_pkg;

  localparam int unsigned MaxColumns = 64;
  localparam int unsigned MaxRows    = 64;

  localparam int unsigned CoordInW = 11;
  localparam int unsigned SizeW    = 10;
  localparam int unsigned CoordW   = 13;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned RowBitsW = 64;
  localparam int unsigned PcW      = 6;

  localparam logic [CfgW-1:0] ColumnsReset = 7'd64;
  localparam logic [CfgW-1:0] RowsReset    = 7'd64;

  localparam logic [CfgIdxW-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS    = 2'd1;

  typedef enum logic [1:0] {
    CMD_LINE     = 2'd0,
    CMD_SQUARE   = 2'd1,
    CMD_TRIANGLE = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_SEG      = 3'd1,
    OP_CHK      = 3'd2,
    OP_RD       = 3'd3,
    OP_WR       = 3'd4,
    OP_ROWRD    = 3'd5,
    OP_DONE     = 3'd6,
    OP_DONE_ROW = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    SEG_LINE   = 3'd0,
    SEG_TOP    = 3'd1,
    SEG_LEFT   = 3'd2,
    SEG_RIGHT  = 3'd3,
    SEG_BOTTOM = 3'd4,
    SEG_LEG_H  = 3'd5,
    SEG_LEG_V  = 3'd6,
    SEG_HYP    = 3'd7
  } seg_e;

  typedef struct packed {
    op_e            op;
    seg_e           seg;
    logic           chk;
    logic [PcW-1:0] tgt;
  } uword_t;

  typedef struct packed {
    op_e  op;
    seg_e seg;
    logic chk;
  } ctrl_t;

  typedef struct packed {
    logic pass;
    logic more;
  } stat_t;

  // program entry and exit points
  localparam logic [PcW-1:0] UC_LINE      = 6'd0;
  localparam logic [PcW-1:0] UC_LINE_END  = 6'd4;
  localparam logic [PcW-1:0] UC_SQUARE    = 6'd5;
  localparam logic [PcW-1:0] UC_SQ_END    = 6'd21;
  localparam logic [PcW-1:0] UC_TRIANGLE  = 6'd22;
  localparam logic [PcW-1:0] UC_TRI_LEG_V = 6'd26;
  localparam logic [PcW-1:0] UC_TRI_HYP   = 6'd30;
  localparam logic [PcW-1:0] UC_TRI_END   = 6'd34;
  localparam logic [PcW-1:0] UC_READ      = 6'd35;
  localparam logic [PcW-1:0] UC_LAST      = 6'd36;

  function automatic uword_t uw(input op_e op, input seg_e seg, input logic chk,
                                input logic [PcW-1:0] tgt);
    uword_t w;
    w.op  = op;
    w.seg = seg;
    w.chk = chk;
    w.tgt = tgt;
    return w;
  endfunction

  function automatic logic [PcW-1:0] rlbt_entry(input cmd_e cmd);
    logic [PcW-1:0] pc;
    unique case (cmd)
      CMD_LINE:     pc = UC_LINE;
      CMD_SQUARE:   pc = UC_SQUARE;
      CMD_TRIANGLE: pc = UC_TRIANGLE;
      CMD_READ:     pc = UC_READ;
      default:      pc = UC_LINE;
    endcase
    return pc;
  endfunction

  function automatic uword_t rlbt_ucode(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // line
      6'd0:  w = uw(OP_SEG, SEG_LINE, 1'b0, '0);
      6'd1:  w = uw(OP_CHK, SEG_LINE, 1'b1, UC_LINE_END);
      6'd2:  w = uw(OP_RD, SEG_LINE, 1'b0, '0);
      6'd3:  w = uw(OP_WR, SEG_LINE, 1'b0, 6'd2);
      6'd4:  w = uw(OP_DONE, SEG_LINE, 1'b0, '0);
      // square: top, left, right, bottom
      6'd5:  w = uw(OP_SEG, SEG_TOP, 1'b0, '0);
      6'd6:  w = uw(OP_CHK, SEG_TOP, 1'b1, UC_SQ_END);
      6'd7:  w = uw(OP_RD, SEG_TOP, 1'b0, '0);
      6'd8:  w = uw(OP_WR, SEG_TOP, 1'b0, 6'd7);
      6'd9:  w = uw(OP_SEG, SEG_LEFT, 1'b0, '0);
      6'd10: w = uw(OP_CHK, SEG_LEFT, 1'b1, UC_SQ_END);
      6'd11: w = uw(OP_RD, SEG_LEFT, 1'b0, '0);
      6'd12: w = uw(OP_WR, SEG_LEFT, 1'b0, 6'd11);
      6'd13: w = uw(OP_SEG, SEG_RIGHT, 1'b0, '0);
      6'd14: w = uw(OP_CHK, SEG_RIGHT, 1'b1, UC_SQ_END);
      6'd15: w = uw(OP_RD, SEG_RIGHT, 1'b0, '0);
      6'd16: w = uw(OP_WR, SEG_RIGHT, 1'b0, 6'd15);
      6'd17: w = uw(OP_SEG, SEG_BOTTOM, 1'b0, '0);
      6'd18: w = uw(OP_CHK, SEG_BOTTOM, 1'b1, UC_SQ_END);
      6'd19: w = uw(OP_RD, SEG_BOTTOM, 1'b0, '0);
      6'd20: w = uw(OP_WR, SEG_BOTTOM, 1'b0, 6'd19);
      6'd21: w = uw(OP_DONE, SEG_LINE, 1'b0, '0);
      // triangle: legs unchecked, hypotenuse sets the result
      6'd22: w = uw(OP_SEG, SEG_LEG_H, 1'b0, '0);
      6'd23: w = uw(OP_CHK, SEG_LEG_H, 1'b0, UC_TRI_LEG_V);
      6'd24: w = uw(OP_RD, SEG_LEG_H, 1'b0, '0);
      6'd25: w = uw(OP_WR, SEG_LEG_H, 1'b0, 6'd24);
      6'd26: w = uw(OP_SEG, SEG_LEG_V, 1'b0, '0);
      6'd27: w = uw(OP_CHK, SEG_LEG_V, 1'b0, UC_TRI_HYP);
      6'd28: w = uw(OP_RD, SEG_LEG_V, 1'b0, '0);
      6'd29: w = uw(OP_WR, SEG_LEG_V, 1'b0, 6'd28);
      6'd30: w = uw(OP_SEG, SEG_HYP, 1'b0, '0);
      6'd31: w = uw(OP_CHK, SEG_HYP, 1'b1, UC_TRI_END);
      6'd32: w = uw(OP_RD, SEG_HYP, 1'b0, '0);
      6'd33: w = uw(OP_WR, SEG_HYP, 1'b0, 6'd32);
      6'd34: w = uw(OP_DONE, SEG_LINE, 1'b0, '0);
      // read row
      6'd35: w = uw(OP_ROWRD, SEG_LINE, 1'b0, '0);
      6'd36: w = uw(OP_DONE_ROW, SEG_LINE, 1'b0, '0);
      default: w = uw(OP_DONE, SEG_LINE, 1'b0, '0);
    endcase
    return w;
  endfunction

endpackage

>>> design/rlbt_sequencer.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module rlbt_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  rlbt_pkg::cmd_e  cmd_i,
  input  rlbt_pkg::stat_t stat_i,
  input  logic            out_free_i,
  output logic            busy_o,
  output logic            fin_o,
  output rlbt_pkg::ctrl_t ctrl_o
);
  import rlbt_pkg::*;

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  uword_t         uw_cur;

  assign uw_cur = rlbt_ucode(pc_q);
  assign busy_o = busy_q;
  assign fin_o  = busy_q && (uw_cur.op == OP_DONE || uw_cur.op == OP_DONE_ROW) && out_free_i;

  always_comb begin
    ctrl_o.op  = busy_q ? uw_cur.op : OP_NOP;
    ctrl_o.seg = uw_cur.seg;
    ctrl_o.chk = uw_cur.chk;
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (in_fire_i) begin
        pc_d   = rlbt_entry(cmd_i);
        busy_d = 1'b1;
      end
    end else begin
      unique case (uw_cur.op)
        OP_CHK: pc_d = stat_i.pass ? pc_q + PcW'(1) : uw_cur.tgt;
        OP_WR:  pc_d = stat_i.more ? uw_cur.tgt : pc_q + PcW'(1);
        OP_DONE, OP_DONE_ROW: begin
          if (out_free_i) busy_d = 1'b0;
        end
        default: pc_d = pc_q + PcW'(1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

`ifndef SYNTH
  a_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> !busy_q) else $error("transfer taken while busy");
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= UC_LAST)) else $error("step counter out of program");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_o |=> !busy_q) else $error("still busy after result");
`endif

endmodule

>>> design/rlbt_datapath.sv
// Datapath: coordinates, segment check, line stepping and canvas memory.
`timescale 1ns / 1ps

module rlbt_datapath #(
  parameter int unsigned MAX_COLUMNS = rlbt_pkg::MaxColumns,
  parameter int unsigned MAX_ROWS    = rlbt_pkg::MaxRows
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_fire_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] x_first_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] y_first_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] x_second_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] y_second_i,
  input  logic        [rlbt_pkg::SizeW-1:0]    shape_size_i,
  input  logic                                 face_left_i,
  input  logic                                 face_up_i,
  input  logic        [rlbt_pkg::CfgW-1:0]     cols_i,
  input  logic        [rlbt_pkg::CfgW-1:0]     rows_i,
  input  rlbt_pkg::ctrl_t                      ctrl_i,
  output rlbt_pkg::stat_t                      stat_o,
  output logic                                 success_o,
  output logic        [rlbt_pkg::RowBitsW-1:0] row_bits_o
);
  import rlbt_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned NW  = (RW > CW) ? RW : CW;
  localparam int unsigned YW  = NW + 2;
  localparam int unsigned RUW = ($clog2(MAX_ROWS + 1) > CfgW) ? $clog2(MAX_ROWS + 1) : CfgW;
  localparam logic signed [YW-1:0] RowsLim = YW'(MAX_ROWS);

  typedef enum logic [1:0] {
    YS_HOLD = 2'd0,
    YS_INC  = 2'd1,
    YS_DEC  = 2'd2
  } ystep_e;

  function automatic logic in_rng(input logic signed [CoordW-1:0] v,
                                  input logic signed [CoordW-1:0] lim);
    return (v >= 0) && (v < lim);
  endfunction

  // captured command
  logic signed [CoordW-1:0] size_s, f_s, x_e, y_e;
  logic signed [CoordW-1:0] x_q, y_q, x2_q, y2_q, xf_q, yf_q, hx_q, vy_q;

  // current segment
  logic signed [CoordW-1:0] sxa, sya, sxb, syb;
  logic signed [CoordW-1:0] xa_q, ya_q, xb_q, yb_q;

  // limits
  logic [CfgW-1:0]          c_use;
  logic [RUW-1:0]           r_use;
  logic signed [CoordW-1:0] c_s, r_s;
  logic                     pass, row_ok;

  // stepping setup
  logic [CW-1:0]          xa_c, xb_c, x_lo, x_hi, xs;
  logic [RW-1:0]          ya_r, yb_r, y_lo, y_hi, ys, yo;
  logic                   vert, horz;
  logic [MAX_COLUMNS-1:0] mask_set, rmask;
  logic signed [YW-1:0]   cury_set;
  logic [NW-1:0]          cnt_set;
  ystep_e                 step_set;
  logic                   shift_set;

  // stepping state
  logic [MAX_COLUMNS-1:0] mask_q;
  logic signed [YW-1:0]   cur_y_q;
  logic [NW-1:0]          cnt_q;
  ystep_e                 step_q;
  logic                   shift_q, skip_q, ok_q;
  logic                   row_in;

  // canvas
  logic [MAX_COLUMNS-1:0] canvas_q [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_vld_q;
  logic [MAX_COLUMNS-1:0] rdata_q, wr_data, col_mask, row_res;
  logic                   rd_vld_q, rd_en, wr_en;
  logic [RW-1:0]          rd_addr, wr_addr;

  assign size_s = $signed({{(CoordW - SizeW){1'b0}}, shape_size_i});
  assign f_s    = size_s - CoordW'(1);
  assign x_e    = CoordW'(x_first_i);
  assign y_e    = CoordW'(y_first_i);

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      x_q  <= x_e;
      y_q  <= y_e;
      x2_q <= CoordW'(x_second_i);
      y2_q <= CoordW'(y_second_i);
      xf_q <= x_e + f_s;
      yf_q <= y_e + f_s;
      hx_q <= face_left_i ? x_e - f_s : x_e + f_s;
      vy_q <= face_up_i ? y_e - f_s : y_e + f_s;
    end
  end

  always_comb begin
    unique case (ctrl_i.seg)
      SEG_LINE:   begin sxa = x_q;  sya = y_q;  sxb = x2_q; syb = y2_q; end
      SEG_TOP:    begin sxa = x_q;  sya = y_q;  sxb = xf_q; syb = y_q;  end
      SEG_LEFT:   begin sxa = x_q;  sya = y_q;  sxb = x_q;  syb = yf_q; end
      SEG_RIGHT:  begin sxa = xf_q; sya = y_q;  sxb = xf_q; syb = yf_q; end
      SEG_BOTTOM: begin sxa = x_q;  sya = yf_q; sxb = xf_q; syb = yf_q; end
      SEG_LEG_H:  begin sxa = x_q;  sya = y_q;  sxb = hx_q; syb = y_q;  end
      SEG_LEG_V:  begin sxa = x_q;  sya = y_q;  sxb = x_q;  syb = vy_q; end
      SEG_HYP:    begin sxa = x_q;  sya = vy_q; sxb = hx_q; syb = y_q;  end
      default:    begin sxa = x_q;  sya = y_q;  sxb = x2_q; syb = y2_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_SEG) begin
      xa_q <= sxa;
      ya_q <= sya;
      xb_q <= sxb;
      yb_q <= syb;
    end
  end

  assign c_use = (cols_i > CfgW'(MAX_COLUMNS)) ? CfgW'(MAX_COLUMNS) : cols_i;
  assign r_use = (RUW'(rows_i) > RUW'(MAX_ROWS)) ? RUW'(MAX_ROWS) : RUW'(rows_i);
  assign c_s   = $signed(CoordW'(c_use));
  assign r_s   = $signed(CoordW'(r_use));

  assign pass   = in_rng(xa_q, c_s) && in_rng(xb_q, c_s) &&
                  in_rng(ya_q, r_s) && in_rng(yb_q, r_s);
  assign row_ok = in_rng(y_q, r_s) && (c_use != '0);
  assign row_in = (cur_y_q >= 0) && (cur_y_q < $signed(YW'(r_use)));

  always_comb begin
    xa_c  = xa_q[CW-1:0];
    xb_c  = xb_q[CW-1:0];
    ya_r  = ya_q[RW-1:0];
    yb_r  = yb_q[RW-1:0];
    vert  = (xa_q == xb_q);
    horz  = (ya_q == yb_q);
    x_lo  = (xa_c < xb_c) ? xa_c : xb_c;
    x_hi  = (xa_c < xb_c) ? xb_c : xa_c;
    y_lo  = (ya_r < yb_r) ? ya_r : yb_r;
    y_hi  = (ya_r < yb_r) ? yb_r : ya_r;
    xs    = (xa_c < xb_c) ? xa_c : xb_c;
    ys    = (xa_c < xb_c) ? ya_r : yb_r;
    yo    = (xa_c < xb_c) ? yb_r : ya_r;
    rmask = ({MAX_COLUMNS{1'b1}} << x_lo) &
            ({MAX_COLUMNS{1'b1}} >> (CW'(MAX_COLUMNS - 1) - x_hi));
    priority if (vert) begin
      mask_set  = MAX_COLUMNS'(1) << xa_c;
      cury_set  = YW'(y_lo);
      cnt_set   = NW'(y_hi - y_lo);
      step_set  = YS_INC;
      shift_set = 1'b0;
    end else if (horz) begin
      mask_set  = rmask;
      cury_set  = YW'(ya_r);
      cnt_set   = '0;
      step_set  = YS_HOLD;
      shift_set = 1'b0;
    end else begin
      mask_set  = MAX_COLUMNS'(1) << xs;
      cury_set  = YW'(ys);
      cnt_set   = NW'(x_hi - x_lo);
      step_set  = (ys < yo) ? YS_INC : YS_DEC;
      shift_set = 1'b1;
    end
  end

  assign rd_en   = ((ctrl_i.op == OP_RD) && row_in) || ((ctrl_i.op == OP_ROWRD) && row_ok);
  assign rd_addr = (ctrl_i.op == OP_RD) ? cur_y_q[RW-1:0] : y_q[RW-1:0];
  assign wr_en   = (ctrl_i.op == OP_WR) && !skip_q;
  assign wr_addr = cur_y_q[RW-1:0];
  assign wr_data = (rd_vld_q ? rdata_q : '0) | mask_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) canvas_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= canvas_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      ok_q      <= 1'b0;
      skip_q    <= 1'b0;
      mask_q    <= '0;
      cur_y_q   <= '0;
      cnt_q     <= '0;
      step_q    <= YS_HOLD;
      shift_q   <= 1'b0;
    end else begin
      if (wr_en) row_vld_q[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_q <= row_vld_q[rd_addr];
      unique case (ctrl_i.op)
        OP_CHK: begin
          if (ctrl_i.chk) ok_q <= pass;
          mask_q  <= mask_set;
          cur_y_q <= cury_set;
          cnt_q   <= cnt_set;
          step_q  <= step_set;
          shift_q <= shift_set;
        end
        OP_RD: skip_q <= !row_in;
        OP_WR: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - NW'(1);
            unique case (step_q)
              YS_INC:  cur_y_q <= cur_y_q + YW'(1);
              YS_DEC:  cur_y_q <= cur_y_q - YW'(1);
              default: cur_y_q <= cur_y_q;
            endcase
            if (shift_q) mask_q <= mask_q << 1;
          end
        end
        OP_ROWRD: ok_q <= row_ok;
        default: ;
      endcase
    end
  end

  assign stat_o.pass = pass;
  assign stat_o.more = (cnt_q != '0);

  assign col_mask   = (c_use >= CfgW'(MAX_COLUMNS)) ? {MAX_COLUMNS{1'b1}}
                                                     : ~({MAX_COLUMNS{1'b1}} << c_use);
  assign row_res    = (ok_q && rd_vld_q) ? (rdata_q & col_mask) : '0;
  assign success_o  = ok_q;
  assign row_bits_o = (ctrl_i.op == OP_DONE_ROW) ? RowBitsW'(row_res) : '0;

`ifndef SYNTH
  a_ok_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op != OP_CHK && ctrl_i.op != OP_ROWRD) |=> $stable(ok_q))
    else $error("result flag changed outside a check step");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_WR && cnt_q != '0) |=> (cnt_q == $past(cnt_q) - NW'(1)))
    else $error("step count did not advance");
  a_wr_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (cur_y_q >= 0 && cur_y_q < RowsLim))
    else $error("canvas write outside memory");
`endif

endmodule

>>> design/raster_line_box_triangle_plotter_top.sv
// Top level of the raster line, box and triangle plotter.
`timescale 1ns / 1ps

// One-bit canvas of MAX_ROWS rows by MAX_COLUMNS columns; commands draw lines, squares and
// triangles or read back one row. One command is worked at a time by a microcoded sequencer;
// a new command is taken when the previous one has placed its result in the output register,
// even if that result is not yet taken. Each line segment takes a select and a check step,
// then a read and a write step per canvas row it touches, for the read-modify-write through
// the single canvas memory port: a horizontal segment is one row, vertical and diagonal
// segments one row per cell. A line is one segment plus a done step, a square up to four
// segments plus a done step, a triangle three plus a done step, a row read a read and a done
// step. Canvas rows carry per-row valid flags cleared by reset, so no clearing pass follows reset.
module raster_line_box_triangle_plotter_top #(
  parameter int unsigned MAX_COLUMNS = rlbt_pkg::MaxColumns,
  parameter int unsigned MAX_ROWS    = rlbt_pkg::MaxRows
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [rlbt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [rlbt_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [1:0]                    command_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] x_first_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] y_first_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] x_second_i,
  input  logic signed [rlbt_pkg::CoordInW-1:0] y_second_i,
  input  logic        [rlbt_pkg::SizeW-1:0]    shape_size_i,
  input  logic                                 face_left_i,
  input  logic                                 face_up_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 success_o,
  output logic        [rlbt_pkg::RowBitsW-1:0] row_bits_o
);
  import rlbt_pkg::*;

  logic [CfgW-1:0]     cols_q, rows_q;
  logic                busy, fin, in_fire, out_free;
  ctrl_t               ctrl;
  stat_t               stat;
  logic                res_success;
  logic [RowBitsW-1:0] res_row;
  logic                out_valid_q, success_q;
  logic [RowBitsW-1:0] row_bits_q;

  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColumnsReset;
      rows_q <= RowsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLUMNS: cols_q <= cfg_data_i;
        CFG_ROWS:    rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rlbt_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .cmd_i      (cmd_e'(command_i)),
    .stat_i     (stat),
    .out_free_i (out_free),
    .busy_o     (busy),
    .fin_o      (fin),
    .ctrl_o     (ctrl)
  );

  rlbt_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .x_first_i    (x_first_i),
    .y_first_i    (y_first_i),
    .x_second_i   (x_second_i),
    .y_second_i   (y_second_i),
    .shape_size_i (shape_size_i),
    .face_left_i  (face_left_i),
    .face_up_i    (face_up_i),
    .cols_i       (cols_q),
    .rows_i       (rows_q),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .success_o    (res_success),
    .row_bits_o   (res_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      success_q  <= res_success;
      row_bits_q <= res_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign success_o   = success_q;
  assign row_bits_o  = row_bits_q;

endmodule
